// ----- design/timestamp_ordered_integration_slots_macros.svh -----
// Assertion macros used by the checker of the integration slot pool
`ifndef TIMESTAMP_ORDERED_INTEGRATION_SLOTS_MACROS_SVH
`define TIMESTAMP_ORDERED_INTEGRATION_SLOTS_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define TOSL_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("slot pool property violated");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define TOSL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("slot pool property violated");

`endif

// ----- design/tosl_pkg.sv -----
// Types and constants of the integration slot pool
`default_nettype none

package tosl_pkg;

  localparam int unsigned TS_W  = 48;
  localparam int unsigned ENG_W = 4;
  localparam int unsigned LEN_W = 16;
  localparam int unsigned SI_W  = 3;
  localparam int unsigned CNT_W = 17;

  localparam logic [CNT_W-1:0] CNT_MAX       = '1;
  localparam logic [CNT_W-1:0] BUDGET_RESET  = 17'd4096;
  localparam logic             REG_BYTES_PER_ENGINE = 1'b0;

  typedef enum logic [1:0] {
    KIND_PKT     = 2'd0,
    KIND_CLAIM   = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_NOP     = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_EXISTING  = 3'd0,
    ST_NEW       = 3'd1,
    ST_NEW_EVICT = 3'd2,
    ST_TOO_OLD   = 3'd3,
    ST_ALL_BUSY  = 3'd4,
    ST_DONE      = 3'd5
  } status_e;

  typedef struct packed {
    kind_e              kind;
    logic [TS_W-1:0]    ts;
    logic               eng_ok;
    logic [ENG_W-1:0]   eng;
    logic [LEN_W-1:0]   off;
    logic [LEN_W-1:0]   len;
    logic [SI_W-1:0]    si;
    logic               si_ok;
  } cmd_t;

  typedef struct packed {
    status_e            status;
    logic [SI_W-1:0]    slot_used;
    logic               evicted;
    logic [SI_W-1:0]    evicted_slot;
    logic               truncated;
    logic               over_count;
    logic               engine_filled;
    logic               integration_complete;
  } res_t;

endpackage

`default_nettype wire

// ----- design/tosl_if.sv -----
// Channel interfaces: packet/command input and result output
`default_nettype none

interface tosl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [47:0] timestamp;
  logic [3:0]  engine_index;
  logic [15:0] byte_offset;
  logic [15:0] byte_length;
  logic [2:0]  slot_index;

  modport source (output valid, mode, timestamp, engine_index, byte_offset, byte_length,
                  slot_index, input ready);
  modport sink   (input valid, mode, timestamp, engine_index, byte_offset, byte_length,
                  slot_index, output ready);
endinterface

interface tosl_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [2:0] slot_used;
  logic       evicted;
  logic [2:0] evicted_slot;
  logic       truncated;
  logic       over_count;
  logic       engine_filled;
  logic       integration_complete;

  modport source (output valid, status, slot_used, evicted, evicted_slot, truncated,
                  over_count, engine_filled, integration_complete, input ready);
  modport sink   (input valid, status, slot_used, evicted, evicted_slot, truncated,
                  over_count, engine_filled, integration_complete, output ready);
endinterface

`default_nettype wire

// ----- design/tosl_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module tosl_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- design/tosl_front.sv -----
// Front end: accepts transactions, classifies them and queues commands
`default_nettype none

module tosl_front #(
  parameter int unsigned SLOTS     = 8,
  parameter int unsigned ENGINES   = 16,
  parameter int unsigned TIME_BITS = 48
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  tosl_in_if.sink        in_i,
  output logic           cmd_valid_o,
  output tosl_pkg::cmd_t cmd_o,
  input  wire logic      cmd_pop_i
);

  localparam int unsigned TW = (TIME_BITS < tosl_pkg::TS_W) ? TIME_BITS : tosl_pkg::TS_W;

  tosl_pkg::cmd_t cls;
  tosl_pkg::cmd_t ent_q [2];
  logic           wr_q;
  logic           rd_q;
  logic [1:0]     cnt_q;
  logic           push;
  logic           pop;

  always_comb begin
    cls        = '0;
    cls.kind   = tosl_pkg::kind_e'(in_i.mode);
    cls.ts     = tosl_pkg::TS_W'(in_i.timestamp[TW-1:0]);
    cls.eng    = in_i.engine_index;
    cls.eng_ok = 32'(in_i.engine_index) < 32'(ENGINES);
    cls.off    = in_i.byte_offset;
    cls.len    = in_i.byte_length;
    cls.si     = in_i.slot_index;
    cls.si_ok  = 32'(in_i.slot_index) < 32'(SLOTS);
  end

  assign in_i.ready  = (cnt_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign pop         = cmd_pop_i && (cnt_q != 2'd0);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = ent_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= cls;
    end
  end

endmodule

`default_nettype wire

// ----- design/tosl_back.sv -----
// Back end: walks the ordered slot chain, evicts, inserts and counts bytes
`default_nettype none

module tosl_back #(
  parameter int unsigned SLOTS     = 8,
  parameter int unsigned ENGINES   = 16,
  parameter int unsigned TIME_BITS = 48
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cmd_valid_i,
  input  wire tosl_pkg::cmd_t                cmd_i,
  output logic                               cmd_pop_o,
  input  wire logic [tosl_pkg::CNT_W-1:0]    bytes_per_engine_i,
  output logic                               res_valid_o,
  output tosl_pkg::res_t                     res_o,
  input  wire logic                          res_ready_i
);

  localparam int unsigned IW    = $clog2(SLOTS);
  localparam int unsigned TW    = (TIME_BITS < tosl_pkg::TS_W) ? TIME_BITS : tosl_pkg::TS_W;
  localparam int unsigned DEPTH = SLOTS * ENGINES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned LW    = $clog2(ENGINES + 1);
  localparam int unsigned CW    = tosl_pkg::CNT_W;
  localparam logic [AW-1:0] ENG_STRIDE = AW'(ENGINES);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_RECENT = 12'b0000_0000_0010,
    S_HEAD   = 12'b0000_0000_0100,
    S_FIND   = 12'b0000_0000_1000,
    S_EVICT  = 12'b0000_0001_0000,
    S_REL    = 12'b0000_0010_0000,
    S_UNLINK = 12'b0000_0100_0000,
    S_TAKE   = 12'b0000_1000_0000,
    S_INS    = 12'b0001_0000_0000,
    S_WALK   = 12'b0010_0000_0000,
    S_UPD_RD = 12'b0100_0000_0000,
    S_UPD_WR = 12'b1000_0000_0000
  } state_e;

  state_e         state_q;
  tosl_pkg::cmd_t cmd_q;

  logic [TW-1:0]  time_q [SLOTS];
  logic [IW-1:0]  nxt_q  [SLOTS];
  logic           nxv_q  [SLOTS];
  logic           busy_q [SLOTS];
  logic           inch_q [SLOTS];
  logic [LW-1:0]  left_q [SLOTS];
  logic [DEPTH-1:0] vbit_q;

  logic [IW-1:0]  head_q, tail_q, free_q, recent_q;
  logic           head_v_q, tail_v_q, free_v_q, recent_v_q;
  logic [IW-1:0]  cur_q, prev_q, vic_q, slot_q, ev_q;
  logic           prev_v_q, ev_v_q;
  tosl_pkg::status_e status_q;
  logic           trunc_q;
  logic [CW-1:0]  clen_q;
  logic           out_v_q;
  tosl_pkg::res_t res_q;

  logic [IW-1:0]  rd_addr;
  logic [TW-1:0]  rd_time;
  logic [IW-1:0]  rd_nxt;
  logic           rd_nxv, rd_busy, rd_inch;
  logic [LW-1:0]  rd_left;
  logic [TW-1:0]  ts;
  logic           out_free;

  logic [AW-1:0]  ram_addr;
  logic [CW-1:0]  ram_rdata;
  logic           ram_we;

  logic [CW-1:0]  budget, off_x, sum, clen, old_cnt, nw;
  logic           trunc;
  logic [CW:0]    nw_wide;
  logic           over, filled, done;
  logic [LW-1:0]  left_new;

  function automatic tosl_pkg::res_t make_res(tosl_pkg::status_e st, logic [IW-1:0] s,
                                              logic ev, logic [IW-1:0] evs, logic tr,
                                              logic ov, logic fi, logic dn);
    tosl_pkg::res_t r;
    r.status               = st;
    r.slot_used            = tosl_pkg::SI_W'(s);
    r.evicted              = ev;
    r.evicted_slot         = ev ? tosl_pkg::SI_W'(evs) : '0;
    r.truncated            = tr;
    r.over_count           = ov;
    r.engine_filled        = fi;
    r.integration_complete = dn;
    return r;
  endfunction

  function automatic tosl_pkg::res_t done_res(logic [tosl_pkg::SI_W-1:0] si);
    tosl_pkg::res_t r;
    r           = '0;
    r.status    = tosl_pkg::ST_DONE;
    r.slot_used = si;
    return r;
  endfunction

  function automatic tosl_pkg::res_t drop_res(tosl_pkg::status_e st);
    tosl_pkg::res_t r;
    r        = '0;
    r.status = st;
    return r;
  endfunction

  always_comb begin
    unique case (state_q)
      S_IDLE:                        rd_addr = IW'(cmd_i.si);
      S_RECENT:                      rd_addr = recent_q;
      S_HEAD, S_INS:                 rd_addr = head_q;
      S_FIND, S_EVICT, S_REL, S_WALK: rd_addr = cur_q;
      S_UNLINK:                      rd_addr = vic_q;
      S_TAKE:                        rd_addr = free_q;
      S_UPD_RD, S_UPD_WR:            rd_addr = slot_q;
      default:                       rd_addr = '0;
    endcase
  end

  assign rd_time  = time_q[rd_addr];
  assign rd_nxt   = nxt_q[rd_addr];
  assign rd_nxv   = nxv_q[rd_addr];
  assign rd_busy  = busy_q[rd_addr];
  assign rd_inch  = inch_q[rd_addr];
  assign rd_left  = left_q[rd_addr];
  assign ts       = cmd_q.ts[TW-1:0];
  assign out_free = !out_v_q || res_ready_i;

  assign cmd_pop_o   = (state_q == S_IDLE) && cmd_valid_i && out_free;
  assign res_valid_o = out_v_q;
  assign res_o       = res_q;

  // Byte count arithmetic: clip in the read cycle, accumulate in the write cycle
  assign ram_addr = AW'(AW'(slot_q) * ENG_STRIDE) + AW'(cmd_q.eng);
  assign ram_we   = (state_q == S_UPD_WR);
  assign budget   = bytes_per_engine_i;
  assign off_x    = CW'(cmd_q.off);
  assign sum      = off_x + CW'(cmd_q.len);
  assign trunc    = sum > budget;
  assign clen     = (off_x >= budget) ? '0 : (trunc ? budget - off_x : CW'(cmd_q.len));
  assign old_cnt  = vbit_q[ram_addr] ? ram_rdata : '0;
  assign nw_wide  = (CW+1)'(old_cnt) + (CW+1)'(clen_q);
  assign nw       = nw_wide[CW] ? tosl_pkg::CNT_MAX : nw_wide[CW-1:0];
  assign over     = nw > budget;
  assign filled   = (nw >= budget) && (old_cnt < budget);
  assign left_new = (rd_left == '0) ? '0 : rd_left - LW'(1);
  assign done     = filled && (left_new == '0);

  tosl_ram #(
    .WIDTH (CW),
    .DEPTH (DEPTH)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (nw),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      head_v_q   <= 1'b0;
      tail_q     <= '0;
      tail_v_q   <= 1'b0;
      recent_q   <= '0;
      recent_v_q <= 1'b0;
      free_q     <= '0;
      free_v_q   <= 1'b1;
      out_v_q    <= 1'b0;
      vbit_q     <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        time_q[i] <= '0;
        nxt_q[i]  <= (i + 1 < SLOTS) ? IW'(i + 1) : '0;
        nxv_q[i]  <= (i + 1 < SLOTS);
        busy_q[i] <= 1'b0;
        inch_q[i] <= 1'b0;
        left_q[i] <= LW'(ENGINES);
      end
    end else begin
      if (res_ready_i) begin
        out_v_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i && out_free) begin
            cmd_q  <= cmd_i;
            ev_v_q <= 1'b0;
            ev_q   <= '0;
            case (cmd_i.kind)
              tosl_pkg::KIND_PKT: begin
                if (!head_v_q) begin
                  if (!free_v_q) begin
                    out_v_q <= 1'b1;
                    res_q   <= drop_res(tosl_pkg::ST_ALL_BUSY);
                  end else begin
                    status_q <= tosl_pkg::ST_NEW;
                    state_q  <= S_TAKE;
                  end
                end else if (recent_v_q) begin
                  state_q <= S_RECENT;
                end else begin
                  state_q <= S_HEAD;
                end
              end
              tosl_pkg::KIND_CLAIM: begin
                if (cmd_i.si_ok && rd_inch) begin
                  busy_q[rd_addr] <= 1'b1;
                end
                out_v_q <= 1'b1;
                res_q   <= done_res(cmd_i.si);
              end
              tosl_pkg::KIND_RELEASE: begin
                if (cmd_i.si_ok && rd_inch && head_v_q) begin
                  vic_q    <= rd_addr;
                  cur_q    <= head_q;
                  prev_v_q <= 1'b0;
                  state_q  <= S_REL;
                end else begin
                  out_v_q <= 1'b1;
                  res_q   <= done_res(cmd_i.si);
                end
              end
              default: begin
                out_v_q <= 1'b1;
                res_q   <= done_res(cmd_i.si);
              end
            endcase
          end
        end
        S_RECENT: begin
          if (rd_inch && (rd_time == ts)) begin
            slot_q   <= recent_q;
            status_q <= tosl_pkg::ST_EXISTING;
            state_q  <= S_UPD_RD;
          end else begin
            state_q <= S_HEAD;
          end
        end
        S_HEAD: begin
          if (ts < rd_time) begin
            if (!free_v_q) begin
              out_v_q <= 1'b1;
              res_q   <= drop_res(tosl_pkg::ST_TOO_OLD);
              state_q <= S_IDLE;
            end else begin
              status_q <= tosl_pkg::ST_NEW;
              state_q  <= S_TAKE;
            end
          end else begin
            cur_q   <= head_q;
            state_q <= S_FIND;
          end
        end
        S_FIND: begin
          if (rd_time == ts) begin
            slot_q   <= cur_q;
            status_q <= tosl_pkg::ST_EXISTING;
            state_q  <= S_UPD_RD;
          end else if (rd_nxv) begin
            cur_q <= rd_nxt;
          end else if (free_v_q) begin
            status_q <= tosl_pkg::ST_NEW;
            state_q  <= S_TAKE;
          end else begin
            cur_q    <= head_q;
            prev_v_q <= 1'b0;
            state_q  <= S_EVICT;
          end
        end
        S_EVICT: begin
          // oldest slot that no reader holds goes first
          if (!rd_busy) begin
            vic_q    <= cur_q;
            ev_q     <= cur_q;
            ev_v_q   <= 1'b1;
            status_q <= tosl_pkg::ST_NEW_EVICT;
            state_q  <= S_UNLINK;
          end else if (rd_nxv) begin
            prev_q   <= cur_q;
            prev_v_q <= 1'b1;
            cur_q    <= rd_nxt;
          end else begin
            out_v_q <= 1'b1;
            res_q   <= drop_res(tosl_pkg::ST_ALL_BUSY);
            state_q <= S_IDLE;
          end
        end
        S_REL: begin
          if (!prev_v_q && (cur_q == vic_q)) begin
            state_q <= S_UNLINK;
          end else if (rd_nxv && (rd_nxt == vic_q)) begin
            prev_q   <= cur_q;
            prev_v_q <= 1'b1;
            state_q  <= S_UNLINK;
          end else if (rd_nxv) begin
            cur_q <= rd_nxt;
          end else begin
            out_v_q <= 1'b1;
            res_q   <= done_res(cmd_q.si);
            state_q <= S_IDLE;
          end
        end
        S_UNLINK: begin
          if (!prev_v_q) begin
            head_q   <= rd_nxt;
            head_v_q <= rd_nxv;
            if (tail_v_q && (tail_q == vic_q)) begin
              tail_q   <= rd_nxt;
              tail_v_q <= rd_nxv;
            end
            if (recent_v_q && (recent_q == vic_q)) begin
              recent_q   <= rd_nxt;
              recent_v_q <= rd_nxv;
            end
          end else begin
            nxt_q[prev_q] <= rd_nxv ? rd_nxt : '0;
            nxv_q[prev_q] <= rd_nxv;
            if (tail_v_q && (tail_q == vic_q)) begin
              tail_q <= prev_q;
            end
            if (recent_v_q && (recent_q == vic_q)) begin
              recent_q <= prev_q;
            end
          end
          // clear the slot and push it on the front of the free chain
          time_q[vic_q] <= '0;
          busy_q[vic_q] <= 1'b0;
          inch_q[vic_q] <= 1'b0;
          left_q[vic_q] <= LW'(ENGINES);
          for (int j = 0; j < DEPTH; j++) begin
            if (IW'(j / ENGINES) == vic_q) begin
              vbit_q[j] <= 1'b0;
            end
          end
          nxt_q[vic_q] <= free_v_q ? free_q : '0;
          nxv_q[vic_q] <= free_v_q;
          free_q       <= vic_q;
          free_v_q     <= 1'b1;
          if (cmd_q.kind == tosl_pkg::KIND_RELEASE) begin
            out_v_q <= 1'b1;
            res_q   <= done_res(cmd_q.si);
            state_q <= S_IDLE;
          end else begin
            state_q <= S_TAKE;
          end
        end
        S_TAKE: begin
          slot_q          <= free_q;
          free_q          <= rd_nxt;
          free_v_q        <= rd_nxv;
          inch_q[free_q]  <= 1'b1;
          busy_q[free_q]  <= 1'b0;
          time_q[free_q]  <= ts;
          state_q         <= S_INS;
        end
        S_INS: begin
          if (!head_v_q) begin
            nxt_q[slot_q] <= '0;
            nxv_q[slot_q] <= 1'b0;
            head_q        <= slot_q;
            head_v_q      <= 1'b1;
            tail_q        <= slot_q;
            tail_v_q      <= 1'b1;
            state_q       <= S_UPD_RD;
          end else if (ts < rd_time) begin
            nxt_q[slot_q] <= head_q;
            nxv_q[slot_q] <= 1'b1;
            head_q        <= slot_q;
            state_q       <= S_UPD_RD;
          end else if (!rd_nxv) begin
            nxt_q[slot_q] <= rd_nxt;
            nxv_q[slot_q] <= 1'b0;
            nxt_q[head_q] <= slot_q;
            nxv_q[head_q] <= 1'b1;
            if (tail_v_q && (tail_q == head_q)) begin
              tail_q <= slot_q;
            end
            state_q <= S_UPD_RD;
          end else begin
            prev_q  <= head_q;
            cur_q   <= rd_nxt;
            state_q <= S_WALK;
          end
        end
        S_WALK: begin
          if (ts < rd_time) begin
            nxt_q[slot_q] <= cur_q;
            nxv_q[slot_q] <= 1'b1;
            nxt_q[prev_q] <= slot_q;
            nxv_q[prev_q] <= 1'b1;
            state_q       <= S_UPD_RD;
          end else if (!rd_nxv) begin
            nxt_q[slot_q] <= rd_nxt;
            nxv_q[slot_q] <= 1'b0;
            nxt_q[cur_q]  <= slot_q;
            nxv_q[cur_q]  <= 1'b1;
            if (tail_v_q && (tail_q == cur_q)) begin
              tail_q <= slot_q;
            end
            state_q <= S_UPD_RD;
          end else begin
            prev_q <= cur_q;
            cur_q  <= rd_nxt;
          end
        end
        S_UPD_RD: begin
          recent_q   <= slot_q;
          recent_v_q <= 1'b1;
          if (cmd_q.eng_ok) begin
            trunc_q <= trunc;
            clen_q  <= clen;
            state_q <= S_UPD_WR;
          end else begin
            out_v_q <= 1'b1;
            res_q   <= make_res(status_q, slot_q, ev_v_q, ev_q, 1'b0, 1'b0, 1'b0, 1'b0);
            state_q <= S_IDLE;
          end
        end
        S_UPD_WR: begin
          vbit_q[ram_addr] <= 1'b1;
          if (filled) begin
            left_q[slot_q] <= left_new;
          end
          out_v_q <= 1'b1;
          res_q   <= make_res(status_q, slot_q, ev_v_q, ev_q, trunc_q, over, filled, done);
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/timestamp_ordered_integration_slots.sv -----
// Top level of the timestamp-ordered integration slot pool
//
// Input channel in_i carries one transaction per item: a packet (mode 0), a
// claim that marks a slot busy (mode 1) or a release that frees a slot
// (mode 2). Output channel out_o returns exactly one result per transaction,
// in order. Both use valid/ready; a transaction moves when both are high.
// The front end queues up to two classified commands; the back end works on
// one command at a time against a chain of slots kept in timestamp order.
// A claim, a release of an unknown slot or mode 3 passes through queue and
// back end without a walk; a packet that hits the recent slot skips the walk;
// a full walk with eviction and ordered insert is paced by the single chain
// read port stepping one slot per cycle. A release walks the ordered chain
// to find the predecessor.
// The APB port holds bytes_per_engine at byte address 0 (reset 4096).
// Reset empties the ordered chain, links all slots into the free chain in
// index order and zeroes every byte count at once. While out_o stalls the
// result register holds and the queue keeps accepting until full.
`default_nettype none

module timestamp_ordered_integration_slots #(
  parameter int unsigned SLOTS     = 8,
  parameter int unsigned ENGINES   = 16,
  parameter int unsigned TIME_BITS = 48
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  tosl_in_if.sink          in_i,
  tosl_out_if.source       out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic                          cmd_valid;
  logic                          cmd_pop;
  tosl_pkg::cmd_t                cmd;
  tosl_pkg::res_t                res;
  logic                          res_valid;
  logic [tosl_pkg::CNT_W-1:0]    bpe_q;
  logic                          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == tosl_pkg::REG_BYTES_PER_ENGINE);
  assign prdata = (paddr[2] == tosl_pkg::REG_BYTES_PER_ENGINE) ? 32'(bpe_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpe_q <= tosl_pkg::BUDGET_RESET;
    end else if (cfg_wr) begin
      bpe_q <= pwdata[tosl_pkg::CNT_W-1:0];
    end
  end

  tosl_front #(
    .SLOTS     (SLOTS),
    .ENGINES   (ENGINES),
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  tosl_back #(
    .SLOTS     (SLOTS),
    .ENGINES   (ENGINES),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_valid_i        (cmd_valid),
    .cmd_i              (cmd),
    .cmd_pop_o          (cmd_pop),
    .bytes_per_engine_i (bpe_q),
    .res_valid_o        (res_valid),
    .res_o              (res),
    .res_ready_i        (out_o.ready)
  );

  assign out_o.valid                = res_valid;
  assign out_o.status               = res.status;
  assign out_o.slot_used            = res.slot_used;
  assign out_o.evicted              = res.evicted;
  assign out_o.evicted_slot         = res.evicted_slot;
  assign out_o.truncated            = res.truncated;
  assign out_o.over_count           = res.over_count;
  assign out_o.engine_filled        = res.engine_filled;
  assign out_o.integration_complete = res.integration_complete;

endmodule

`default_nettype wire

// ----- design/tosl_chk.sv -----
// Port-level checker for the integration slot pool, bound to the top level
`default_nettype none
`include "timestamp_ordered_integration_slots_macros.svh"

module tosl_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [2:0] status_i,
  input wire logic [2:0] slot_used_i,
  input wire logic       evicted_i,
  input wire logic       truncated_i,
  input wire logic       engine_filled_i,
  input wire logic       integration_complete_i
);

  // a stalled result holds
  `TOSL_ASSERT_NEXT(out_hold_a, out_valid_i && !out_ready_i, out_valid_i && $stable(status_i) && $stable(slot_used_i))

  // dropped packets land nowhere and touch no counts
  `TOSL_ASSERT(drop_clean_a, out_valid_i && (status_i == tosl_pkg::ST_TOO_OLD || status_i == tosl_pkg::ST_ALL_BUSY), slot_used_i == 3'd0 && !evicted_i && !truncated_i && !engine_filled_i)

  // eviction is reported exactly with the evicting status
  `TOSL_ASSERT(evict_flag_a, out_valid_i, evicted_i == (status_i == tosl_pkg::ST_NEW_EVICT))

  // completion only ever comes with the packet that fills an engine
  `TOSL_ASSERT(complete_a, out_valid_i && integration_complete_i, engine_filled_i)

endmodule

bind timestamp_ordered_integration_slots tosl_chk u_chk (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .out_valid_i            (out_o.valid),
  .out_ready_i            (out_o.ready),
  .status_i               (out_o.status),
  .slot_used_i            (out_o.slot_used),
  .evicted_i              (out_o.evicted),
  .truncated_i            (out_o.truncated),
  .engine_filled_i        (out_o.engine_filled),
  .integration_complete_i (out_o.integration_complete)
);

`default_nettype wire
